// ===== rtl/dfpt_pkg.sv =====
// ----------------------------------------------------------------------------
// dfpt_pkg
// Shared types and constants for the deauth flood pair tracker.
// ----------------------------------------------------------------------------
package dfpt_pkg;

   // Field widths
   localparam int ADDR_W   = 48;
   localparam int TIME_W   = 48;
   localparam int COUNT_W  = 16;
   localparam int TOTAL_W  = 32;
   localparam int INDEX_W  = 4;
   localparam int CSR_DW   = 32;
   localparam int CSR_AW   = 3;

   // Frame decode
   localparam logic [1:0] FTYPE_MGMT     = 2'd0;
   localparam logic [3:0] SUBT_DEAUTH    = 4'd12;
   localparam logic [3:0] SUBTYPE_DISAS  = 4'd10;

   // Commands
   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Register indexes (byte address bit 2)
   localparam logic REG_WINDOW_MS  = 1'b0;
   localparam logic REG_THRESHOLD  = 1'b1;

   // Register reset values
   localparam logic [COUNT_W-1:0] WINDOW_MS_RST = 16'd2000;
   localparam logic [COUNT_W-1:0] THRESHOLD_RST = 16'd5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // Control sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WREAD,
      ST_UPDATE,
      ST_DONE
   } dfpt_state_type;

endpackage

// ===== rtl/dfpt_if.sv =====
// ----------------------------------------------------------------------------
// dfpt_if
// Valid/ready channel interfaces for frame requests and tracker responses.
// ----------------------------------------------------------------------------
interface dfpt_req_if
   import dfpt_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              command;
   logic [1:0]        frame_type;
   logic [3:0]        frame_subtype;
   logic [ADDR_W-1:0] transmitter_addr;
   logic [ADDR_W-1:0] receiver_addr;
   logic [TIME_W-1:0] time_ms;

   modport source (
      output valid, command, frame_type, frame_subtype,
             transmitter_addr, receiver_addr, time_ms,
      input  ready
   );
   modport sink (
      input  valid, command, frame_type, frame_subtype,
             transmitter_addr, receiver_addr, time_ms,
      output ready
   );
endinterface

interface dfpt_rsp_if
   import dfpt_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               frame_matched;
   logic               alert;
   logic [INDEX_W-1:0] entry_index;
   logic               table_overflow;
   logic [COUNT_W-1:0] pair_count;
   logic [TOTAL_W-1:0] frames_seen_total;

   modport source (
      output valid, frame_matched, alert, entry_index, table_overflow,
             pair_count, frames_seen_total,
      input  ready
   );
   modport sink (
      input  valid, frame_matched, alert, entry_index, table_overflow,
             pair_count, frames_seen_total,
      output ready
   );
endinterface

// ===== rtl/dfpt_ram.sv =====
// ----------------------------------------------------------------------------
// dfpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/deauth_flood_pair_tracker_core.sv =====
// ----------------------------------------------------------------------------
// deauth_flood_pair_tracker_core
// Per (transmitter, receiver) pair deauth/disassoc flood detector with a
// fixed counting window per pair, held in key and window memories.
// ----------------------------------------------------------------------------
// Sequence: a counted frame scans keys up to its matching slot, then reads
//   and updates its window entry; a new pair skips the window read; a full
//   table scans all keys, then uses slot 0; clear or ignored frames skip both.
// Throughput: one frame at a time; the key scan reads one entry per cycle
//   through the key memory read port and sets the rate.
// Reset: empties the table (fill count to zero), clears the running total,
//   loads register defaults. Memories are not swept; no clearing pass.
// ----------------------------------------------------------------------------
module deauth_flood_pair_tracker_core
   import dfpt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   dfpt_req_if.sink          req_chan,
   dfpt_rsp_if.source        rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int EXT_W   = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
   localparam int KEY_W   = 2 * ADDR_W;
   localparam int WIN_W   = TIME_W + COUNT_W;

   // control state
   dfpt_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] window_ms_ff, window_ms_in;
   logic [COUNT_W-1:0] threshold_ff, threshold_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic               out_vld_ff, out_vld_in;

   // item payload
   logic [ADDR_W-1:0]  tx_ff, tx_in;
   logic [ADDR_W-1:0]  rx_ff, rx_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic               new_ff, new_in;
   logic               ovf_ff, ovf_in;

   // pending result
   logic               res_matched_ff, res_matched_in;
   logic               res_alert_ff, res_alert_in;
   logic [INDEX_W-1:0] res_index_ff, res_index_in;
   logic               res_ovf_ff, res_ovf_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;

   // output register
   logic               out_matched_ff, out_matched_in;
   logic               out_alert_ff, out_alert_in;
   logic [INDEX_W-1:0] out_index_ff, out_index_in;
   logic               out_ovf_ff, out_ovf_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic [TOTAL_W-1:0] out_total_ff, out_total_in;

   // memory ports
   logic               key_wr_en, key_rd_en;
   logic [IDX_W-1:0]   key_wr_addr, key_rd_addr;
   logic [KEY_W-1:0]   key_wr_data, key_rd_data;
   logic               win_wr_en, win_rd_en;
   logic [IDX_W-1:0]   win_wr_addr, win_rd_addr;
   logic [WIN_W-1:0]   win_wr_data, win_rd_data;

   // decode and status
   logic               accept, is_frame, csr_write;
   logic               scan_more, key_hit, scan_end, table_full, out_free;
   logic [TIME_W-1:0]  cur_start, base_start;
   logic [COUNT_W-1:0] cur_count, base_count, next_count;
   logic [TIME_W:0]    elapsed;
   logic               expire;
   logic [EXT_W-1:0]   slot_ext;

   dfpt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   dfpt_ram #(.WIDTH(WIN_W), .DEPTH(TABLE_DEPTH)) u_win_ram (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (win_wr_addr),
      .wr_data (win_wr_data),
      .rd_en   (win_rd_en),
      .rd_addr (win_rd_addr),
      .rd_data (win_rd_data)
   );

   // handshake and status terms
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept     = req_chan.valid && req_chan.ready;
   assign is_frame   = (req_chan.command == CMD_FRAME) &&
                       (req_chan.frame_type == FTYPE_MGMT) &&
                       ((req_chan.frame_subtype == SUBT_DEAUTH) ||
                        (req_chan.frame_subtype == SUBTYPE_DISAS));
   assign scan_more  = (scan_ff < used_ff);
   assign key_hit    = cmp_vld_ff && (key_rd_data == {tx_ff, rx_ff});
   assign scan_end   = !cmp_vld_ff && !scan_more;
   assign table_full = (used_ff == CNT_W'(TABLE_DEPTH));
   assign out_free   = !out_vld_ff || rsp_chan.ready;

   // window arithmetic for the update cycle
   assign cur_start  = new_ff ? now_ff : win_rd_data[WIN_W-1:COUNT_W];
   assign cur_count  = new_ff ? '0 : win_rd_data[COUNT_W-1:0];
   assign elapsed    = {1'b0, now_ff} - {1'b0, cur_start};
   // no borrow and nonzero means time moved forward
   assign expire     = !elapsed[TIME_W] && (elapsed[TIME_W-1:0] != '0) &&
                       (elapsed[TIME_W-1:0] > TIME_W'(window_ms_ff));
   assign base_start = expire ? now_ff : cur_start;
   assign base_count = expire ? '0 : cur_count;
   assign next_count = (base_count == COUNT_MAX) ? COUNT_MAX : base_count + 1'b1;
   assign slot_ext   = EXT_W'(slot_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = is_frame ? ST_SEARCH : ST_DONE;
            end
         end
         ST_SEARCH: begin
            if (key_hit) begin
               state_in = ST_WREAD;
            end else if (scan_end) begin
               state_in = table_full ? ST_WREAD : ST_UPDATE;
            end
         end
         ST_WREAD:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      used_in        = used_ff;
      total_in       = total_ff;
      scan_in        = scan_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      tx_in          = tx_ff;
      rx_in          = rx_ff;
      now_in         = now_ff;
      slot_in        = slot_ff;
      new_in         = new_ff;
      ovf_in         = ovf_ff;
      res_matched_in = res_matched_ff;
      res_alert_in   = res_alert_ff;
      res_index_in   = res_index_ff;
      res_ovf_in     = res_ovf_ff;
      res_count_in   = res_count_ff;
      key_wr_en      = 1'b0;
      key_wr_addr    = used_ff[IDX_W-1:0];
      key_wr_data    = {tx_ff, rx_ff};
      key_rd_en      = 1'b0;
      key_rd_addr    = scan_ff[IDX_W-1:0];
      win_wr_en      = 1'b0;
      win_wr_addr    = slot_ff;
      win_wr_data    = {base_start, next_count};
      win_rd_en      = 1'b0;
      win_rd_addr    = slot_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tx_in          = req_chan.transmitter_addr;
               rx_in          = req_chan.receiver_addr;
               now_in         = req_chan.time_ms;
               scan_in        = '0;
               res_matched_in = 1'b0;
               res_alert_in   = 1'b0;
               res_index_in   = '0;
               res_ovf_in     = 1'b0;
               res_count_in   = '0;
               if (req_chan.command == CMD_CLEAR) begin
                  used_in = '0;
               end else if (is_frame) begin
                  total_in = total_ff + 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            // issue one key read per cycle, compare the previous one
            if (scan_more) begin
               key_rd_en  = 1'b1;
               scan_in    = scan_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
            end
            if (key_hit) begin
               cmp_vld_in = 1'b0;
               slot_in    = cmp_idx_ff;
               new_in     = 1'b0;
               ovf_in     = 1'b0;
            end else if (scan_end) begin
               if (table_full) begin
                  slot_in = '0;
                  new_in  = 1'b0;
                  ovf_in  = 1'b1;
               end else begin
                  // allocate the next free slot
                  slot_in   = used_ff[IDX_W-1:0];
                  new_in    = 1'b1;
                  ovf_in    = 1'b0;
                  key_wr_en = 1'b1;
                  used_in   = used_ff + 1'b1;
               end
            end
         end
         ST_WREAD: begin
            win_rd_en = 1'b1;
         end
         ST_UPDATE: begin
            win_wr_en      = 1'b1;
            res_matched_in = 1'b1;
            res_alert_in   = (next_count == threshold_ff);
            res_index_in   = slot_ext[INDEX_W-1:0];
            res_ovf_in     = ovf_ff;
            res_count_in   = next_count;
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   // output register
   always_comb begin
      out_vld_in     = out_vld_ff;
      out_matched_in = out_matched_ff;
      out_alert_in   = out_alert_ff;
      out_index_in   = out_index_ff;
      out_ovf_in     = out_ovf_ff;
      out_count_in   = out_count_ff;
      out_total_in   = out_total_ff;
      if (out_vld_ff && rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         out_vld_in     = 1'b1;
         out_matched_in = res_matched_ff;
         out_alert_in   = res_alert_ff;
         out_index_in   = res_index_ff;
         out_ovf_in     = res_ovf_ff;
         out_count_in   = res_count_ff;
         out_total_in   = total_ff;
      end
   end

   // configuration registers
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      window_ms_in = window_ms_ff;
      threshold_in = threshold_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_WINDOW_MS: window_ms_in = csr_pwdata[COUNT_W-1:0];
            REG_THRESHOLD: threshold_in = csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_WINDOW_MS: csr_prdata = CSR_DW'(window_ms_ff);
         REG_THRESHOLD: csr_prdata = CSR_DW'(threshold_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         total_ff     <= '0;
         window_ms_ff <= WINDOW_MS_RST;
         threshold_ff <= THRESHOLD_RST;
         scan_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         window_ms_ff <= window_ms_in;
         threshold_ff <= threshold_in;
         scan_ff      <= scan_in;
         cmp_vld_ff   <= cmp_vld_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tx_ff          <= tx_in;
      rx_ff          <= rx_in;
      now_ff         <= now_in;
      cmp_idx_ff     <= cmp_idx_in;
      slot_ff        <= slot_in;
      new_ff         <= new_in;
      ovf_ff         <= ovf_in;
      res_matched_ff <= res_matched_in;
      res_alert_ff   <= res_alert_in;
      res_index_ff   <= res_index_in;
      res_ovf_ff     <= res_ovf_in;
      res_count_ff   <= res_count_in;
      out_matched_ff <= out_matched_in;
      out_alert_ff   <= out_alert_in;
      out_index_ff   <= out_index_in;
      out_ovf_ff     <= out_ovf_in;
      out_count_ff   <= out_count_in;
      out_total_ff   <= out_total_in;
   end

   // response channel
   assign rsp_chan.valid             = out_vld_ff;
   assign rsp_chan.frame_matched     = out_matched_ff;
   assign rsp_chan.alert             = out_alert_ff;
   assign rsp_chan.entry_index       = out_index_ff;
   assign rsp_chan.table_overflow    = out_ovf_ff;
   assign rsp_chan.pair_count        = out_count_ff;
   assign rsp_chan.frames_seen_total = out_total_ff;

   // checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (CNT_W'(cmp_idx_ff) < used_ff))
      else $error("key compare outside filled slots");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.command == CMD_CLEAR)) |=> (used_ff == '0))
      else $error("clear did not empty the table");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response loaded outside done state");

   a_ovf_slot0: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ovf_ff) |-> (out_index_ff == '0 && out_matched_ff))
      else $error("overflow result not on slot zero");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the deauth flood pair tracker. A driver feeds frames
// and clear commands from a pending queue. A behavioral tracker model predicts
// each result, and a monitor compares every response transfer against the
// oldest prediction. Phases cover window/threshold settings, source and sink
// backpressure mixes, table overflow and repeated frames of one pair.
// ----------------------------------------------------------------------------
module tb;
   import dfpt_pkg::*;

   localparam int TRACK_DEPTH   = 16;
   localparam int POOL_PAIRS    = 20;
   localparam int DRAIN_CYCLES  = TRACK_DEPTH + 8;
   localparam int LIMIT_CYCLES  = 250_000;
   localparam int REPEAT_FRAMES = 20;

   typedef struct packed {
      logic              command;
      logic [1:0]        ftype;
      logic [3:0]        fsub;
      logic [ADDR_W-1:0] tx;
      logic [ADDR_W-1:0] rx;
      logic [TIME_W-1:0] tm;
   } req_item_type;

   typedef struct packed {
      logic               matched;
      logic               alert;
      logic [INDEX_W-1:0] index;
      logic               overflow;
      logic [COUNT_W-1:0] count;
      logic [TOTAL_W-1:0] total;
   } verdict_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   dfpt_req_if req_bus ();
   dfpt_rsp_if rsp_bus ();

   deauth_flood_pair_tracker_core #(
      .TABLE_DEPTH (TRACK_DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Tracker model state
   logic [ADDR_W-1:0]  key_tx    [TRACK_DEPTH];
   logic [ADDR_W-1:0]  key_rx    [TRACK_DEPTH];
   logic [TIME_W-1:0]  win_start [TRACK_DEPTH];
   logic [COUNT_W-1:0] win_count [TRACK_DEPTH];
   int                 slots_used   = 0;
   logic [TOTAL_W-1:0] frames_total = '0;
   logic [COUNT_W-1:0] win_len      = WINDOW_MS_RST;
   logic [COUNT_W-1:0] alert_at     = THRESHOLD_RST;

   // Stimulus and scoreboard
   req_item_type frame_q[$];
   verdict_type  verdict_q[$];
   req_item_type next_frame;
   req_item_type seen_frame;
   verdict_type  got;
   verdict_type  want;
   logic     req_taken;
   int       src_idle_pct  = 0;
   int       sink_stall_pct = 0;
   int       mismatch_count = 0;
   int       cycle_count    = 0;

   // Random pair pool and time cursor
   logic [ADDR_W-1:0] pool_tx [POOL_PAIRS];
   logic [ADDR_W-1:0] pool_rx [POOL_PAIRS];
   logic [TIME_W-1:0] now_ms;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predict the result of one accepted transfer and update the table
   function automatic verdict_type track_frame(req_item_type f);
      verdict_type v;
      int       slot;
      int       i;
      bit       hit;
      v    = '0;
      slot = 0;
      hit  = 1'b0;
      if (f.command == CMD_CLEAR) begin
         slots_used = 0;
      end else if (f.ftype == FTYPE_MGMT &&
                   (f.fsub == SUBT_DEAUTH || f.fsub == SUBTYPE_DISAS)) begin
         frames_total = frames_total + 1'b1;
         for (i = 0; i < slots_used; i++) begin
            if (!hit && key_tx[i] == f.tx && key_rx[i] == f.rx) begin
               slot = i;
               hit  = 1'b1;
            end
         end
         if (!hit) begin
            if (slots_used < TRACK_DEPTH) begin
               slot            = slots_used;
               key_tx[slot]    = f.tx;
               key_rx[slot]    = f.rx;
               win_start[slot] = f.tm;
               win_count[slot] = '0;
               slots_used++;
            end else begin
               // table full: slot 0 absorbs the frame, keeps its key
               v.overflow = 1'b1;
            end
         end
         // only a strictly positive elapsed time past the window restarts it
         if (f.tm > win_start[slot] && (f.tm - win_start[slot]) > TIME_W'(win_len)) begin
            win_start[slot] = f.tm;
            win_count[slot] = '0;
         end
         if (win_count[slot] != COUNT_MAX)
            win_count[slot] = win_count[slot] + 1'b1;
         v.matched = 1'b1;
         v.alert   = (win_count[slot] == alert_at);
         v.index   = INDEX_W'(slot);
         v.count   = win_count[slot];
      end
      v.total = frames_total;
      return v;
   endfunction

   function automatic logic [47:0] rand48();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[47:0];
   endfunction

   function automatic req_item_type mk_frame(logic cmd, logic [1:0] ftype, logic [3:0] fsub,
                                             logic [47:0] tx, logic [47:0] rx,
                                             logic [47:0] tm);
      req_item_type f;
      f.command = cmd;
      f.ftype   = ftype;
      f.fsub    = fsub;
      f.tx      = tx;
      f.rx      = rx;
      f.tm      = tm;
      return f;
   endfunction

   // Append one item to the pending queue
   task automatic queue_frame(input req_item_type f);
      frame_q.insert(frame_q.size(), f);
   endtask

   // Mostly well-formed deauth/disassoc traffic over a small pair pool,
   // with some noise frames and occasional clears
   function automatic req_item_type random_frame();
      req_item_type f;
      int     pick;
      int     idx;
      pick = $urandom_range(99);
      f    = mk_frame(CMD_FRAME, FTYPE_MGMT, SUBT_DEAUTH, '0, '0, now_ms);
      if (pick < 3) begin
         f = mk_frame(CMD_CLEAR, 2'($urandom), 4'($urandom), rand48(), rand48(), rand48());
      end else if (pick < 15) begin
         f = mk_frame(CMD_FRAME, 2'($urandom), 4'($urandom), rand48(), rand48(), now_ms);
      end else begin
         idx  = $urandom_range(1) ? $urandom_range(3) : $urandom_range(POOL_PAIRS - 1);
         pick = $urandom_range(99);
         if (pick < 4)
            now_ms = now_ms - 48'($urandom_range(40));
         else if (pick < 10)
            now_ms = now_ms + 48'(win_len) + 48'($urandom_range(2));
         else
            now_ms = now_ms + 48'($urandom_range(win_len / 32 + 1));
         f.fsub = $urandom_range(1) ? SUBT_DEAUTH : SUBTYPE_DISAS;
         f.tx   = pool_tx[idx];
         f.rx   = pool_rx[idx];
         f.tm   = now_ms;
      end
      return f;
   endfunction

   // Register write: setup then access, completes when pready is seen
   task automatic write_reg(input logic reg_sel, input logic [COUNT_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= CSR_DW'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_sel == REG_WINDOW_MS)
         win_len = value;
      else
         alert_at = value;
   endtask

   // Block until every pending frame is sent and every result checked
   task automatic wait_drained();
      while (frame_q.size() != 0 || req_bus.valid || verdict_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic [COUNT_W-1:0] window, input logic [COUNT_W-1:0] thr,
                           input int src_pct, input int sink_pct);
      wait_drained();
      write_reg(REG_WINDOW_MS, window);
      write_reg(REG_THRESHOLD, thr);
      src_idle_pct   = src_pct;
      sink_stall_pct = sink_pct;
   endtask

   task automatic run_random(input logic [COUNT_W-1:0] window, input logic [COUNT_W-1:0] thr,
                             input int src_pct, input int sink_pct, input int n_items);
      req_item_type f;
      int     counted;
      int     i;
      set_mode(window, thr, src_pct, sink_pct);
      // odd pairs share a transmitter with the pair below them
      for (i = 0; i < POOL_PAIRS; i++) begin
         pool_tx[i] = (i % 2 == 1) ? pool_tx[i - 1] : rand48();
         pool_rx[i] = rand48();
      end
      now_ms  = rand48();
      counted = 0;
      while (counted < n_items) begin
         f = random_frame();
         queue_frame(f);
         counted++;
      end
      wait_drained();
   endtask

   // Request driver: new transfer only once the previous one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (frame_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
            next_frame               = frame_q.pop_front();
            req_bus.command          <= next_frame.command;
            req_bus.frame_type       <= next_frame.ftype;
            req_bus.frame_subtype    <= next_frame.fsub;
            req_bus.transmitter_addr <= next_frame.tx;
            req_bus.receiver_addr    <= next_frame.rx;
            req_bus.time_ms          <= next_frame.tm;
            req_bus.valid            <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response sink backpressure
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= sink_stall_pct);
   end

   // Monitor: check results first, then predict the newly accepted frame
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.frame_matched, rsp_bus.alert, rsp_bus.entry_index,
                   rsp_bus.table_overflow, rsp_bus.pair_count, rsp_bus.frames_seen_total};
            if (verdict_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: matched=%0b alert=%0b idx=%0d ovf=%0b %s",
                           got.matched, got.alert, got.index, got.overflow,
                           $sformatf("cnt=%0d tot=%0d", got.count, got.total));
            end else begin
               want = verdict_q.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("expected: matched=%0b alert=%0b idx=%0d ovf=%0b cnt=%0d tot=%0d",
                              want.matched, want.alert, want.index, want.overflow,
                              want.count, want.total);
                     $display("actual:   matched=%0b alert=%0b idx=%0d ovf=%0b cnt=%0d tot=%0d",
                              got.matched, got.alert, got.index, got.overflow,
                              got.count, got.total);
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen_frame = {req_bus.command, req_bus.frame_type, req_bus.frame_subtype,
                          req_bus.transmitter_addr, req_bus.receiver_addr, req_bus.time_ms};
            verdict_q.insert(verdict_q.size(), track_frame(seen_frame));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Test sequence
   initial begin
      logic [47:0] pair_a_tx;
      logic [47:0] pair_b_rx;
      logic [47:0] sat_tx;
      logic [47:0] sat_rx;
      logic [47:0] sat_tm;
      int          i;
      pair_a_tx                = '1;
      pair_b_rx                = '1;
      reset                    = 1'b1;
      req_bus.valid            = 1'b0;
      req_bus.command          = CMD_FRAME;
      req_bus.frame_type       = '0;
      req_bus.frame_subtype    = '0;
      req_bus.transmitter_addr = '0;
      req_bus.receiver_addr    = '0;
      req_bus.time_ms          = '0;
      rsp_bus.ready            = 1'b0;
      csr_psel                 = 1'b0;
      csr_penable              = 1'b0;
      csr_pwrite               = 1'b0;
      csr_paddr                = '0;
      csr_pwdata               = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: decode, window edges, time going backward, clear
      set_mode(16'd10, 16'd3, 0, 0);
      queue_frame(mk_frame(CMD_FRAME, 2'd1, SUBT_DEAUTH, pair_a_tx, '0, 48'd0));
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, 4'd11, pair_a_tx, '0, 48'd0));
      queue_frame(mk_frame(CMD_FRAME, 2'd3, 4'd15, pair_a_tx, '0, 48'd0));
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, 4'd0, '0, '0, 48'd0));
      queue_frame(mk_frame(CMD_FRAME, 2'd2, SUBTYPE_DISAS, '0, '0, 48'd0));
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBT_DEAUTH, pair_a_tx, '0, 48'd100));
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBTYPE_DISAS, pair_a_tx, '0, 48'd105));
      // elapsed equal to the window: no restart, count hits threshold
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBT_DEAUTH, pair_a_tx, '0, 48'd110));
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBT_DEAUTH, pair_a_tx, '0, 48'd111));
      // one past the window: restart
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBT_DEAUTH, pair_a_tx, '0, 48'd122));
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBT_DEAUTH, pair_a_tx, '0, 48'd50));
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBT_DEAUTH, '0, pair_b_rx, '1));
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBT_DEAUTH, '0, pair_b_rx, 48'd0));
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBTYPE_DISAS, pair_a_tx, pair_b_rx, 48'd7));
      queue_frame(mk_frame(CMD_CLEAR, 2'd3, 4'd15, '1, '1, '1));
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBT_DEAUTH, '0, pair_b_rx, 48'd200));
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBT_DEAUTH, pair_a_tx, '0, 48'd201));

      // Threshold zero: never alerts
      wait_drained();
      write_reg(REG_THRESHOLD, 16'd0);
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBT_DEAUTH, pair_a_tx, '0, 48'd202));
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBTYPE_DISAS, pair_a_tx, '0, 48'd203));
      queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBT_DEAUTH, '0, pair_b_rx, 48'd204));

      // Random phases across settings and backpressure mixes
      run_random(16'd50,    16'd3, 0,  0,  150);
      run_random(16'd0,     16'd1, 82, 0,  150);
      run_random(16'd65535, 16'd7, 0,  82, 150);
      run_random(16'd300,   16'd2, 38, 38, 150);

      // Repeated pair at a fixed time: count climbs through the threshold
      set_mode(16'd0, 16'd12, 0, 0);
      sat_tx = rand48();
      sat_rx = rand48();
      sat_tm = rand48();
      queue_frame(mk_frame(CMD_CLEAR, 2'd0, 4'd0, '0, '0, '0));
      for (i = 0; i < REPEAT_FRAMES; i++)
         queue_frame(mk_frame(CMD_FRAME, FTYPE_MGMT, SUBT_DEAUTH, sat_tx, sat_rx, sat_tm));

      wait_drained();
      if (mismatch_count == 0 && verdict_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
